@@ rtl/core/astg_pkg.sv @@
package astg_pkg;

	localparam int MAX_LOG2_DEF      = 10;
	localparam int ANGLE_BITS_DEF    = 16;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ATAN_ENTRIES      = 24;
	localparam int ROOT_BITS         = 33;
	localparam int ISQRT_STEPS       = 33;
	localparam int CFG_ADDR_W        = 2;
	localparam int CFG_DATA_W        = 40;
	localparam logic [34:0] CORDIC_START = 35'sd652032874;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_GRID_LOG2 = 2'd0,
		REG_STEP_X    = 2'd1,
		REG_STEP_Y    = 2'd2,
		REG_Z_LAMBDA  = 2'd3
	} cfg_reg_t;

	function automatic logic [31:0] atan_turn(input int idx);
		logic [31:0] r;
		begin
			unique case (idx)
				0: r = 32'd536870912;
				1: r = 32'd316933406;
				2: r = 32'd167458907;
				3: r = 32'd85004756;
				4: r = 32'd42667331;
				5: r = 32'd21354465;
				6: r = 32'd10679838;
				7: r = 32'd5340245;
				8: r = 32'd2670163;
				9: r = 32'd1335087;
				10: r = 32'd667544;
				11: r = 32'd333772;
				12: r = 32'd166886;
				13: r = 32'd83443;
				14: r = 32'd41722;
				15: r = 32'd20861;
				16: r = 32'd10430;
				17: r = 32'd5215;
				18: r = 32'd2608;
				19: r = 32'd1304;
				20: r = 32'd652;
				21: r = 32'd326;
				22: r = 32'd163;
				23: r = 32'd81;
				default: r = 32'd0;
			endcase
			return r;
		end
	endfunction

endpackage

@@ rtl/core/astg_sqrt_cell.sv @@
module astg_sqrt_cell (
	input  logic        clk,
	input  logic        en,
	input  logic [65:0] rem_i,
	input  logic [32:0] root_i,
	input  logic [65:0] val_i,
	output logic [65:0] rem_o,
	output logic [32:0] root_o,
	output logic [65:0] val_o
);
	logic [67:0] trial;
	logic [67:0] rem_sh;

	always_comb begin
		rem_sh = {rem_i, val_i[65:64]};
		trial  = {rem_sh} - {33'd0, root_i, 2'b01};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!trial[67]) begin
				rem_o  <= trial[65:0];
				root_o <= {root_i[31:0], 1'b1};
			end else begin
				rem_o  <= rem_sh[65:0];
				root_o <= {root_i[31:0], 1'b0};
			end
			val_o <= {val_i[63:0], 2'b00};
		end
	end
endmodule

@@ rtl/core/astg_cordic_cell.sv @@
module astg_cordic_cell #(
	parameter int SHIFT = 0
) (
	input  logic               clk,
	input  logic               en,
	input  logic signed [34:0] x_i,
	input  logic signed [34:0] y_i,
	input  logic signed [33:0] z_i,
	output logic signed [34:0] x_o,
	output logic signed [34:0] y_o,
	output logic signed [33:0] z_o
);
	import astg_pkg::*;

	logic signed [33:0] at;

	always_comb at = $signed({2'b00, atan_turn(SHIFT)});

	always_ff @(posedge clk) begin
		if (en) begin
			if (!z_i[33]) begin
				x_o <= x_i - (y_i >>> SHIFT);
				y_o <= y_i + (x_i >>> SHIFT);
				z_o <= z_i - at;
			end else begin
				x_o <= x_i + (y_i >>> SHIFT);
				y_o <= y_i - (x_i >>> SHIFT);
				z_o <= z_i + at;
			end
		end
	end
endmodule

@@ rtl/core/angular_spectrum_transfer_gen_unit.sv @@
// channel   | group          | tdata / tuser
// s_axis    | tvalid,tready  | tdata[9:0] row_index, [19:10] col_index
// m_axis    | tvalid,tready  | tdata[15:0] coef_real, [31:16] coef_imag; tuser evanescent
// cfg       | valid,ready    | index[1:0], data[39:0]
// One item per cycle while the output is not stalled. The square-root cell chain sets
// the latency. Reset clears the valid chain and config registers but sets grid_log2 to 9.
// Output stall freezes the whole pipe; a skid register keeps s_axis_tready registered.
module angular_spectrum_transfer_gen_unit
	import astg_pkg::*;
#(
	parameter int MAX_LOG2      = MAX_LOG2_DEF,
	parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [23:0]           s_axis_tdata,  // row_index, col_index
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [31:0]           m_axis_tdata,  // coef_real, coef_imag
	output logic                  m_axis_tuser,  // evanescent
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_ADDR_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	localparam int NST  = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
	localparam int LAT  = 6 + ISQRT_STEPS + 3 + NST + 1;
	localparam int GW   = $clog2(MAX_LOG2 + 1);

	logic [3:0]  grid_q;
	logic [31:0] stepx_q, stepy_q;
	logic signed [39:0] zl_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q <= 4'd9; stepx_q <= '0; stepy_q <= '0; zl_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_GRID_LOG2: grid_q  <= cfg_data[3:0];
				REG_STEP_X:    stepx_q <= cfg_data[31:0];
				REG_STEP_Y:    stepy_q <= cfg_data[31:0];
				REG_Z_LAMBDA:  zl_q    <= cfg_data[39:0];
				default: ;
			endcase
		end
	end

	// pipe enable and valid chain
	logic en;
	logic [LAT-1:0] vld_q;
	logic out_full;
	assign en = !out_full || m_axis_tready;

	// input skid
	logic        skid_v_q;
	logic [19:0] skid_d_q;
	logic        in_v;
	logic [19:0] in_d;
	assign s_axis_tready = !skid_v_q;
	assign in_v = skid_v_q || s_axis_tvalid;
	assign in_d = skid_v_q ? skid_d_q : s_axis_tdata[19:0];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) skid_v_q <= 1'b0;
		else if (en) skid_v_q <= 1'b0;
		else if (s_axis_tvalid && s_axis_tready) skid_v_q <= 1'b1;
	end
	always_ff @(posedge clk)
		if (!en && s_axis_tvalid && s_axis_tready) skid_d_q <= s_axis_tdata[19:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[LAT-2:0], in_v};
	end

	// s1: magnitudes
	logic [GW-1:0] g;
	logic [MAX_LOG2-1:0] mask, half, ir, ic, mr, mc;
	always_comb begin
		if (grid_q < 4'd1) g = GW'(1);
		else if (32'(grid_q) > MAX_LOG2) g = GW'(MAX_LOG2);
		else g = GW'(grid_q);
		mask = MAX_LOG2'(({{MAX_LOG2{1'b0}}, 1'b1} << g) - 1'b1);
		half = MAX_LOG2'({{MAX_LOG2{1'b0}}, 1'b1} << (g - 1'b1));
		ir = MAX_LOG2'(in_d[9:0]) & mask;
		ic = MAX_LOG2'(in_d[19:10]) & mask;
		mr = (ir <= half) ? ir : MAX_LOG2'(-ir) & mask;
		mc = (ic <= half) ? ic : MAX_LOG2'(-ic) & mask;
		if (ir == half) mr = half;
		if (ic == half) mc = half;
	end
	logic [MAX_LOG2:0] mr_s1, mc_s1;
	always_ff @(posedge clk)
		if (en) begin
			mr_s1 <= (ir == half && g == GW'(MAX_LOG2)) ? {1'b1, {MAX_LOG2{1'b0}}} >> 1 : {1'b0, mr};
			mc_s1 <= (ic == half && g == GW'(MAX_LOG2)) ? {1'b1, {MAX_LOG2{1'b0}}} >> 1 : {1'b0, mc};
		end

	// s2: u = mag * step
	logic [MAX_LOG2+32:0] ux_s2, uy_s2;
	always_ff @(posedge clk)
		if (en) begin
			ux_s2 <= (MAX_LOG2+33)'(mc_s1) * (MAX_LOG2+33)'(stepx_q);
			uy_s2 <= (MAX_LOG2+33)'(mr_s1) * (MAX_LOG2+33)'(stepy_q);
		end

	// s3: range check; s4: squares
	logic big_s3;
	logic [32:0] ax_s3, ay_s3;
	always_ff @(posedge clk)
		if (en) begin
			big_s3 <= (ux_s2 > (MAX_LOG2+33)'(64'h1_0000_0000)) ||
			          (uy_s2 > (MAX_LOG2+33)'(64'h1_0000_0000));
			ax_s3 <= ux_s2[32:0];
			ay_s3 <= uy_s2[32:0];
		end
	logic [65:0] sqx_s4, sqy_s4;
	logic big_s4;
	always_ff @(posedge clk)
		if (en) begin
			sqx_s4 <= 66'(ax_s3) * 66'(ax_s3);
			sqy_s4 <= 66'(ay_s3) * 66'(ay_s3);
			big_s4 <= big_s3;
		end
	logic [33:0] tot;
	always_comb tot = 34'(sqx_s4[65:32]) + 34'(sqy_s4[65:32]);
	logic ev_s5;
	logic [32:0] arg_s5;
	always_ff @(posedge clk)
		if (en) begin
			ev_s5  <= big_s4 || (tot > 34'h1_0000_0000);
			arg_s5 <= (big_s4 || tot > 34'h1_0000_0000) ? 33'd0 : 33'(34'h1_0000_0000 - tot);
		end
	logic ev_s6;
	logic full_s6;
	logic [65:0] v_s6;
	always_ff @(posedge clk)
		if (en) begin
			ev_s6 <= ev_s5;
			full_s6 <= arg_s5[32];
			v_s6 <= {arg_s5[31:0], 32'd0, 2'b00} >> 2;
		end

	// square-root cell chain
	logic [65:0] srem [ISQRT_STEPS+1];
	logic [32:0] sroot [ISQRT_STEPS+1];
	logic [65:0] sval [ISQRT_STEPS+1];
	logic [ISQRT_STEPS:0] sev, sfull;
	assign srem[0] = '0;
	assign sroot[0] = '0;
	assign sval[0] = v_s6;
	assign sev[0] = ev_s6;
	assign sfull[0] = full_s6;
	for (genvar k = 0; k < ISQRT_STEPS; k++) begin : g_sq
		logic [65:0] r_n; logic [32:0] q_n; logic [65:0] v_n;
		logic e_h, f_h;
		astg_sqrt_cell u_cell (.clk(clk), .en(en), .rem_i(srem[k]), .root_i(sroot[k]),
			.val_i(sval[k]), .rem_o(r_n), .root_o(q_n), .val_o(v_n));
		always_ff @(posedge clk)
			if (en) begin
				e_h <= sev[k]; f_h <= sfull[k];
			end
		assign srem[k+1] = r_n;
		assign sroot[k+1] = q_n;
		assign sval[k+1] = v_n;
		assign sev[k+1] = e_h;
		assign sfull[k+1] = f_h;
	end

	// product in two halves, then angle
	logic [32:0] root;
	logic signed [16:0] rlo;
	always_comb begin
		root = sfull[ISQRT_STEPS] ? 33'h1_0000_0000 : sroot[ISQRT_STEPS];
		rlo  = $signed({1'b0, root[15:0]});
	end
	logic signed [56:0] plo_s7;
	logic [31:0] phi_s7;
	logic ev_s7;
	always_ff @(posedge clk)
		if (en) begin
			plo_s7 <= zl_q * rlo;
			phi_s7 <= zl_q[31:0] * {15'd0, root[32:16]};
			ev_s7 <= sev[ISQRT_STEPS];
		end
	logic [47:0] prod_s8;
	logic ev_s8;
	always_ff @(posedge clk)
		if (en) begin
			prod_s8 <= plo_s7[47:0] + {phi_s7, 16'd0};
			ev_s8 <= ev_s7;
		end
	logic [31:0] theta;
	logic [47:0] ph;
	always_comb begin
		ph = 48'(-prod_s8);
		theta = {ph[47 -: ANGLE_BITS], {(32-ANGLE_BITS){1'b0}}};
	end
	logic flip_s9, ev_s9;
	logic signed [33:0] z_s9;
	always_ff @(posedge clk)
		if (en) begin
			ev_s9 <= ev_s8;
			if (theta[31] != theta[30]) begin
				flip_s9 <= 1'b1;
				z_s9 <= 34'($signed(theta - 32'h8000_0000));
			end else begin
				flip_s9 <= 1'b0;
				z_s9 <= 34'($signed(theta));
			end
		end

	// CORDIC cell chain
	logic signed [34:0] cx [NST+1];
	logic signed [34:0] cy [NST+1];
	logic signed [33:0] cz [NST+1];
	logic [NST:0] cf, ce;
	assign cx[0] = CORDIC_START;
	assign cy[0] = '0;
	assign cz[0] = z_s9;
	assign cf[0] = flip_s9;
	assign ce[0] = ev_s9;
	for (genvar k = 0; k < NST; k++) begin : g_cd
		logic signed [34:0] x_n, y_n; logic signed [33:0] z_n;
		logic f_h, e_h;
		astg_cordic_cell #(.SHIFT(k)) u_cell (.clk(clk), .en(en), .x_i(cx[k]), .y_i(cy[k]),
			.z_i(cz[k]), .x_o(x_n), .y_o(y_n), .z_o(z_n));
		always_ff @(posedge clk)
			if (en) begin
				f_h <= cf[k]; e_h <= ce[k];
			end
		assign cx[k+1] = x_n;
		assign cy[k+1] = y_n;
		assign cz[k+1] = z_n;
		assign cf[k+1] = f_h;
		assign ce[k+1] = e_h;
	end

	function automatic logic [15:0] q15(input logic signed [35:0] v);
		logic signed [35:0] r;
		begin
			r = (v + 36'sd16384) >>> 15;
			if (r > 36'sd32767) return 16'h7FFF;
			if (r < -36'sd32768) return 16'h8000;
			return r[15:0];
		end
	endfunction

	logic signed [35:0] fx, fy;
	always_comb begin
		fx = cf[NST] ? -36'(cx[NST]) : 36'(cx[NST]);
		fy = cf[NST] ? -36'(cy[NST]) : 36'(cy[NST]);
	end
	logic [31:0] od_q;
	logic        ou_q;
	always_ff @(posedge clk)
		if (en) begin
			od_q <= {q15(fy), q15(fx)};
			ou_q <= ce[NST];
		end
	assign out_full = vld_q[LAT-1];
	assign m_axis_tvalid = out_full;
	assign m_axis_tdata = od_q;
	assign m_axis_tuser = ou_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output lost under stall");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[15:0] == 16'h7FFF)
		else $error("evanescent coefficient wrong");
	assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> !s_axis_tready)
		else $error("skid overrun");
endmodule

@@ tb/tb_angular_spectrum_transfer_gen_unit.sv @@
`timescale 1ns / 100ps

module tb_angular_spectrum_transfer_gen_unit;
	import astg_pkg::*;

	localparam int  PIPE_DEPTH  = 6 + 33 + 3 + CORDIC_STAGES_DEF + 1;
	localparam int  CYCLE_LIMIT = 400000;
	localparam int  STAGES      = (CORDIC_STAGES_DEF < 24) ? CORDIC_STAGES_DEF : 24;
	localparam longint unsigned UNIT_Q32 = 64'd1 << 32;
	localparam longint TURN_ANGLE [24] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};

	typedef struct packed {
		logic signed [15:0] re;
		logic signed [15:0] im;
		logic               ev;
	} coef_t;

	class coef_scoreboard;
		logic [3:0]  grid_log2;
		logic [31:0] step_x;
		logic [31:0] step_y;
		longint      z_turns;
		coef_t       coef_q[$];
		int          mismatches;

		function new();
			grid_log2  = 4'd9;
			step_x     = '0;
			step_y     = '0;
			z_turns    = 0;
			mismatches = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [39:0] val);
			case (idx)
				REG_GRID_LOG2: grid_log2 = val[3:0];
				REG_STEP_X:    step_x    = val[31:0];
				REG_STEP_Y:    step_y    = val[31:0];
				REG_Z_LAMBDA:  z_turns   = longint'(signed'(val));
				default: ;
			endcase
		endfunction

		function longint unsigned freq_term(logic [9:0] idx, int g, logic [31:0] step);
			longint unsigned n, i, mag;
			n   = 64'd1 << g;
			i   = longint'(idx) & (n - 1);
			mag = (i <= n / 2) ? i : n - i;
			return mag * step;
		endfunction

		function longint unsigned root_q32(longint unsigned v);
			longint unsigned res, b;
			res = 0;
			b   = 64'd1 << 62;
			while (b > v)
				b >>= 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v  -= res + b;
					res = (res >> 1) + b;
				end else begin
					res >>= 1;
				end
				b >>= 2;
			end
			return res;
		endfunction

		function logic signed [15:0] round_q15(longint v);
			longint r;
			r = (v + 64'sd16384) >>> 15;
			if (r > 32767)
				r = 32767;
			if (r < -32768)
				r = -32768;
			return r[15:0];
		endfunction

		function void note_point(logic [9:0] row, logic [9:0] col);
			int              g, i;
			longint unsigned ux, uy, sqx, sqy, tot, radicand, root, phase, theta;
			longint          zr, x, y, xn;
			logic            flip;
			coef_t           c;
			g = grid_log2;
			if (g < 1)
				g = 1;
			if (g > MAX_LOG2_DEF)
				g = MAX_LOG2_DEF;
			ux       = freq_term(col, g, step_x);
			uy       = freq_term(row, g, step_y);
			radicand = 0;
			c.ev     = 1'b0;
			if (ux > UNIT_Q32 || uy > UNIT_Q32) begin
				c.ev = 1'b1;
			end else begin
				sqx = (ux == UNIT_Q32) ? UNIT_Q32 : (ux * ux) >> 32;
				sqy = (uy == UNIT_Q32) ? UNIT_Q32 : (uy * uy) >> 32;
				tot = sqx + sqy;
				if (tot > UNIT_Q32)
					c.ev = 1'b1;
				else
					radicand = UNIT_Q32 - tot;
			end
			root  = (radicand >= UNIT_Q32) ? UNIT_Q32 : root_q32(radicand << 32);
			phase = (64'd0 - longint'(z_turns) * root) & ((64'd1 << 48) - 1);
			theta = ((phase >> (48 - ANGLE_BITS_DEF)) << (32 - ANGLE_BITS_DEF)) & 64'hFFFF_FFFF;
			flip  = 1'b0;
			if (theta >= (64'd1 << 30) && theta < (64'd3 << 30)) begin
				theta = (theta - (64'd1 << 31)) & 64'hFFFF_FFFF;
				flip  = 1'b1;
			end
			zr = (theta >= (64'd1 << 31)) ? longint'(theta) - longint'(UNIT_Q32) : longint'(theta);
			x  = 652032874;
			y  = 0;
			for (i = 0; i < STAGES; i++) begin
				if (zr >= 0) begin
					xn  = x - (y >>> i);
					y   = y + (x >>> i);
					zr -= TURN_ANGLE[i];
				end else begin
					xn  = x + (y >>> i);
					y   = y - (x >>> i);
					zr += TURN_ANGLE[i];
				end
				x = xn;
			end
			if (flip) begin
				x = -x;
				y = -y;
			end
			c.re = round_q15(x);
			c.im = round_q15(y);
			coef_q = {coef_q, c};
		endfunction

		function void check_coef(coef_t got);
			coef_t exp_c;
			if (coef_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transaction: re=%0d im=%0d ev=%0b",
						got.re, got.im, got.ev);
				return;
			end
			exp_c = coef_q.pop_front();
			if (got !== exp_c) begin
				mismatches++;
				if (mismatches <= 10)
					$display("coef mismatch: exp re=%0d im=%0d ev=%0b, got re=%0d im=%0d ev=%0b",
						exp_c.re, exp_c.im, exp_c.ev, got.re, got.im, got.ev);
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [23:0]           s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [31:0]           m_axis_tdata;
	logic                  m_axis_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_ADDR_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	coef_scoreboard sb;
	int             cycle_cnt;
	int             burst_left;
	int             stall_mode;

	angular_spectrum_transfer_gen_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_coef('{re: m_axis_tdata[15:0], im: m_axis_tdata[31:16], ev: m_axis_tuser});
	end

	// stall pattern: open stretches, random stalls, periodic stalls
	always @(negedge clk) begin
		if (cycle_cnt % 64 == 0)
			stall_mode <= $urandom_range(0, 2);
		case (stall_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= $urandom_range(0, 1);
			default: m_axis_tready <= (cycle_cnt % 7) < 4;
		endcase
	end

	task automatic write_reg(cfg_reg_t idx, logic [39:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_grid(logic [3:0] g, logic [31:0] sx, logic [31:0] sy, logic [39:0] z);
		write_reg(REG_GRID_LOG2, 40'(g));
		write_reg(REG_STEP_X, 40'(sx));
		write_reg(REG_STEP_Y, 40'(sy));
		write_reg(REG_Z_LAMBDA, z);
	endtask

	task automatic send_point(logic [9:0] row, logic [9:0] col);
		if (burst_left == 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(0, 5)) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end else begin
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'd0, col, row};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_point(row, col);
		burst_left--;
	endtask

	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (sb.coef_q.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 4) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_step(int g);
		int ge;
		ge = (g < 1) ? 1 : (g > MAX_LOG2_DEF) ? MAX_LOG2_DEF : g;
		if ($urandom_range(0, 3) == 0)
			return $urandom;
		return 32'(longint'($urandom) & ((64'd1 << (33 - ge)) - 1));
	endfunction

	initial begin
		int          ph, k;
		logic [3:0]  g;
		logic [39:0] z;
		sb            = new();
		cycle_cnt     = 0;
		stall_mode    = 0;
		burst_left    = 0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_GRID_LOG2;
		cfg_data      = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings, then exact unit axis term, zero radicand, wrap
		send_point(10'd0, 10'd0);
		send_point(10'd1023, 10'd256);
		drain();
		set_grid(4'd2, 32'h8000_0000, 32'd0, 40'h00_0003_8000);
		send_point(10'd0, 10'd0);
		send_point(10'd0, 10'd1);
		send_point(10'd0, 10'd2);
		send_point(10'd3, 10'd3);
		send_point(10'd1023, 10'd6);
		drain();
		set_grid(4'd10, 32'hFFFF_FFFF, 32'hC000_0000, 40'h7F_FFFF_FFFF);
		send_point(10'd0, 10'd0);
		send_point(10'd0, 10'd1);
		send_point(10'd1, 10'd0);
		send_point(10'd512, 10'd512);
		send_point(10'd1023, 10'd2);
		drain();
		set_grid(4'd0, 32'h6000_0000, 32'h6000_0000, 40'h80_0000_0000);
		send_point(10'd0, 10'd1);
		send_point(10'd1, 10'd1);
		send_point(10'd1022, 10'd1023);
		drain();
		set_grid(4'd15, 32'h0040_0000, 32'h0080_0000, 40'hFF_FFFF_0001);
		send_point(10'd511, 10'd513);
		send_point(10'd1023, 10'd1023);
		send_point(10'd300, 10'd700);
		drain();

		for (ph = 0; ph < 10; ph++) begin
			g = (ph == 0) ? 4'd10 : (ph == 1) ? 4'd1 : 4'($urandom_range(0, 15));
			case ($urandom_range(0, 3))
				0: z = 40'h7F_FFFF_FFFF;
				1: z = 40'h80_0000_0000;
				default: z = 40'({$urandom, $urandom});
			endcase
			set_grid(g, pick_step(g), pick_step(g), z);
			for (k = 0; k < 120; k++)
				send_point(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
			drain();
		end

		if (sb.mismatches == 0 && sb.coef_q.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
